@@ sv/msap_pkg.sv @@
// Shared types and score constants for the address predictor.
package msap_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_REP_CHK,
    S_REP_IA,
    S_REP_UA,
    S_REP_IB,
    S_REP_UB,
    S_REP_OI,
    S_REP_OU,
    S_STR_INIT,
    S_STR_I,
    S_STR_U,
    S_STR_LA,
    S_STR_CNT,
    S_STR_SEL,
    S_STR_K,
    S_TR_INIT,
    S_TR_I,
    S_TR_U,
    S_REC_INIT,
    S_REC_AI,
    S_REC_AU,
    S_REC_BI,
    S_REC_BU,
    S_PREV,
    S_PREV2,
    S_WIN_INIT,
    S_WIN_I,
    S_WIN_U,
    S_OF_CHK,
    S_OF_I,
    S_OF_U,
    S_DONE
  } state_t;

  localparam int unsigned SCORE_REPEAT = 120;
  localparam int unsigned SCORE_STRIDE = 100;
  localparam int unsigned SCORE_LATEST = 60;
  localparam int unsigned SCORE_TRANS  = 80;
  localparam int unsigned TRANS_STEP   = 5;
  localparam int unsigned SCORE_RECENT = 40;
  localparam int unsigned SCORE_PREV   = 25;
  localparam int unsigned SCORE_PREV2  = 20;
  localparam int unsigned FIRST_STEP   = 4;
  localparam int unsigned STRIDE_STEPS = 4;
  localparam int unsigned MIN_REPEATS  = 2;

endpackage

@@ sv/msap_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module msap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/multi_strategy_address_predictor_core.sv @@
// Address predictor: one predicted next address per observed address.
//
// Input channel: address with address_valid / address_stall. Output channel:
// prediction with prediction_valid / prediction_stall.
// Every accepted address yields exactly one prediction, made from the
// history before it; the address is then appended to the history ring.
// One word is worked on at a time; address_stall is high from accept until
// the prediction is loaded into the output register.
// The work runs as a sequence of scans over n history entries and a
// window of w = min(n, RECENT_SPAN): block and stride checks, the
// transition scan, the window count, an offer into the candidate table
// for each candidate found, and a final pick over the table.
// Every step reads one word from the history RAM or the candidate RAM,
// so those single read ports set the pace. The first word after reset
// skips the scans. A stalled output register holds its word; the next
// prediction waits for it, while a new address is taken as soon as the
// previous one is loaded. Reset empties the history; no clearing pass.
module multi_strategy_address_predictor_core
  import msap_pkg::*;
#(
  parameter int HISTORY_DEPTH   = 1024,
  parameter int CANDIDATE_LIMIT = 256,
  parameter int PERIOD_LIMIT    = 16,
  parameter int STRIDE_SPAN     = 8,
  parameter int RECENT_SPAN     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        address_valid,
  output logic        address_stall,
  input  logic [63:0] address,
  output logic        prediction_valid,
  input  logic        prediction_stall,
  output logic [63:0] prediction
);

  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int HW  = $clog2(HISTORY_DEPTH);
  localparam int KW  = $clog2(CANDIDATE_LIMIT);
  localparam int KCW = $clog2(CANDIDATE_LIMIT + 1);
  localparam int PW  = $clog2(PERIOD_LIMIT + 2);
  localparam int SIW = $clog2(STRIDE_SPAN);
  localparam int SCW = $clog2(STRIDE_SPAN + 1);
  localparam int RFW = $clog2(RECENT_SPAN + 1);
  localparam int SW  = CW + 4;
  localparam int EW  = 64 + SW + CW;
  localparam int XW  = CW + 8;

  function automatic logic [HW-1:0] phys(input logic [CW-1:0] li, input logic [HW-1:0] hd);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(li);
    if (s >= (CW+1)'(HISTORY_DEPTH)) begin
      s = s - (CW+1)'(HISTORY_DEPTH);
    end
    return s[HW-1:0];
  endfunction

  state_t state, state_next, ret, ret_next;

  logic [CW-1:0]  n, n_next;
  logic [HW-1:0]  head, head_next;
  logic [63:0]    last, last_next, prev, prev_next, cur, cur_next, pred, pred_next;
  logic [63:0]    rval, rval_next;
  logic [PW-1:0]  p, p_next, o, o_next;
  logic [SCW-1:0] dc, dc_next, i, i_next, fs, fs_next, best_cnt, best_cnt_next;
  logic [SIW-1:0] pa, pa_next, pb, pb_next, d_idx;
  logic [63:0]    diffs [STRIDE_SPAN];
  logic           d_shift;
  logic [63:0]    d_new;
  logic [63:0]    cur_d, cur_d_next, best, best_next, predv, predv_next;
  logic [2:0]     k, k_next;
  logic [CW-1:0]  ix, ix_next, jx, jx_next, rstart, rstart_next;
  logic [RFW-1:0] fr, fr_next;
  logic [KCW-1:0] cand_cnt, cand_cnt_next;
  logic [KW-1:0]  ck, ck_next;
  logic [63:0]    oaddr, oaddr_next, ba, ba_next;
  logic [SW-1:0]  oscore, oscore_next, bs, bs_next;
  logic           otrans, otrans_next;
  logic [63:0]    outd, outd_next;
  logic           outv, outv_next;

  logic           of_go, of_trans;
  logic [63:0]    of_addr;
  logic [SW-1:0]  of_score;
  state_t         of_ret;

  logic [CW-1:0]  h_log;
  logic           h_we;
  logic [HW-1:0]  h_waddr;
  logic [63:0]    h_rdata;
  logic           c_we;
  logic [KW-1:0]  c_waddr, c_raddr;
  logic [EW-1:0]  c_wdata, c_rdata;

  logic [63:0]    ca, sdelta, slatest;
  logic [SW-1:0]  cs, eff, tscore;
  logic [CW-1:0]  ct;
  logic [SCW-1:0] fs_new;
  logic [RFW-1:0] fr_new;
  state_t         nxt;

  msap_ram #(.WIDTH(64), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (cur),
    .raddr (phys(h_log, head)),
    .rdata (h_rdata)
  );

  msap_ram #(.WIDTH(EW), .DEPTH(CANDIDATE_LIMIT)) u_cand (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign ca = c_rdata[EW-1 -: 64];
  assign cs = c_rdata[CW +: SW];
  assign ct = c_rdata[CW-1:0];
  assign tscore = SW'(SCORE_TRANS) + SW'(ct) * SW'(TRANS_STEP);
  assign eff = (ct != '0 && tscore > cs) ? tscore : cs;
  assign sdelta = last - prev;
  assign slatest = last + sdelta;

  assign address_stall = (state != S_IDLE);
  assign prediction_valid = outv;
  assign prediction = outd;

  always_comb begin
    state_next = state;
    ret_next = ret;
    n_next = n;
    head_next = head;
    last_next = last;
    prev_next = prev;
    cur_next = cur;
    pred_next = pred;
    rval_next = rval;
    p_next = p;
    o_next = o;
    dc_next = dc;
    i_next = i;
    fs_next = fs;
    best_cnt_next = best_cnt;
    pa_next = pa;
    pb_next = pb;
    cur_d_next = cur_d;
    best_next = best;
    predv_next = predv;
    k_next = k;
    ix_next = ix;
    jx_next = jx;
    rstart_next = rstart;
    fr_next = fr;
    cand_cnt_next = cand_cnt;
    ck_next = ck;
    oaddr_next = oaddr;
    oscore_next = oscore;
    otrans_next = otrans;
    ba_next = ba;
    bs_next = bs;
    outd_next = outd;
    outv_next = outv;
    of_go = 1'b0;
    of_trans = 1'b0;
    of_addr = '0;
    of_score = '0;
    of_ret = S_IDLE;
    h_log = '0;
    h_we = 1'b0;
    h_waddr = '0;
    c_we = 1'b0;
    c_waddr = '0;
    c_wdata = '0;
    c_raddr = ck;
    d_idx = pb;
    d_shift = 1'b0;
    d_new = h_rdata - rval;
    fs_new = fs;
    fr_new = fr;
    nxt = S_IDLE;

    if (outv && !prediction_stall) begin
      outv_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (address_valid) begin
          cur_next = address;
          cand_cnt_next = '0;
          if (n == '0) begin
            pred_next = address + 64'(FIRST_STEP);
            state_next = S_DONE;
          end else begin
            p_next = PW'(1);
            state_next = S_REP_CHK;
          end
        end
      end
      // shortest period whose last two blocks match
      S_REP_CHK: begin
        o_next = '0;
        if (XW'(p) <= XW'(PERIOD_LIMIT) && (XW'(p) << 1) <= XW'(n)) begin
          state_next = S_REP_IA;
        end else begin
          state_next = S_STR_INIT;
        end
      end
      S_REP_IA: begin
        h_log = CW'(XW'(n) - (XW'(p) << 1) + XW'(o));
        state_next = S_REP_UA;
      end
      S_REP_UA: begin
        rval_next = h_rdata;
        state_next = S_REP_IB;
      end
      S_REP_IB: begin
        h_log = CW'(XW'(n) - XW'(p) + XW'(o));
        state_next = S_REP_UB;
      end
      S_REP_UB: begin
        if (h_rdata != rval) begin
          p_next = p + PW'(1);
          state_next = S_REP_CHK;
        end else if (XW'(o) + XW'(1) == XW'(p)) begin
          o_next = '0;
          state_next = S_REP_OI;
        end else begin
          o_next = o + PW'(1);
          state_next = S_REP_IA;
        end
      end
      S_REP_OI: begin
        h_log = CW'(XW'(n) - XW'(p) + XW'(o));
        state_next = S_REP_OU;
      end
      S_REP_OU: begin
        o_next = o + PW'(1);
        of_go = 1'b1;
        of_addr = h_rdata;
        of_score = SW'(SCORE_REPEAT) - SW'(o);
        of_ret = (XW'(o) + XW'(1) == XW'(p)) ? S_STR_INIT : S_REP_OI;
      end
      S_STR_INIT: begin
        if (n < CW'(2)) begin
          state_next = S_REC_INIT;
        end else begin
          dc_next = (XW'(n) - XW'(1) > XW'(STRIDE_SPAN)) ? SCW'(STRIDE_SPAN)
                                                          : SCW'(n - CW'(1));
          i_next = '0;
          best_cnt_next = '0;
          best_next = '0;
          state_next = S_STR_I;
        end
      end
      S_STR_I: begin
        h_log = CW'(XW'(n) - XW'(1) - XW'(dc) + XW'(i));
        state_next = S_STR_U;
      end
      S_STR_U: begin
        rval_next = h_rdata;
        d_shift = (i != '0);
        if (i == dc) begin
          pa_next = SIW'(dc - SCW'(1));
          state_next = S_STR_LA;
        end else begin
          i_next = i + SCW'(1);
          state_next = S_STR_I;
        end
      end
      // diffs[dc-1] is the oldest difference; walk down so the first one wins ties
      S_STR_LA: begin
        d_idx = pa;
        cur_d_next = diffs[d_idx];
        pb_next = '0;
        fs_next = '0;
        state_next = S_STR_CNT;
      end
      S_STR_CNT: begin
        d_idx = pb;
        fs_new = fs + SCW'(diffs[d_idx] == cur_d);
        fs_next = fs_new;
        if (SCW'(pb) + SCW'(1) == dc) begin
          if (fs_new > best_cnt) begin
            best_cnt_next = fs_new;
            best_next = cur_d;
          end
          if (pa == '0) begin
            state_next = S_STR_SEL;
          end else begin
            pa_next = pa - SIW'(1);
            state_next = S_STR_LA;
          end
        end else begin
          pb_next = pb + SIW'(1);
        end
      end
      S_STR_SEL: begin
        if (best_cnt >= SCW'(MIN_REPEATS) && best != '0) begin
          k_next = 3'd1;
          predv_next = last + best;
          state_next = S_STR_K;
        end else if (sdelta != '0 && !slatest[63]) begin
          of_go = 1'b1;
          of_addr = slatest;
          of_score = SW'(SCORE_LATEST);
          of_ret = S_TR_INIT;
        end else begin
          state_next = S_TR_INIT;
        end
      end
      S_STR_K: begin
        if (k > 3'(STRIDE_STEPS)) begin
          state_next = S_TR_INIT;
        end else begin
          k_next = k + 3'd1;
          predv_next = predv + best;
          // skip predictions that are negative as signed values
          if (!predv[63]) begin
            of_go = 1'b1;
            of_addr = predv;
            of_score = SW'(SCORE_STRIDE) + SW'(best_cnt) - SW'(k);
            of_ret = S_STR_K;
          end
        end
      end
      S_TR_INIT: begin
        ix_next = '0;
        state_next = S_TR_I;
      end
      S_TR_I: begin
        h_log = ix;
        state_next = S_TR_U;
      end
      S_TR_U: begin
        rval_next = h_rdata;
        ix_next = ix + CW'(1);
        nxt = (ix == n - CW'(1)) ? S_REC_INIT : S_TR_I;
        if (ix != '0 && rval == last) begin
          of_go = 1'b1;
          of_trans = 1'b1;
          of_addr = h_rdata;
          of_ret = nxt;
        end else begin
          state_next = nxt;
        end
      end
      S_REC_INIT: begin
        rstart_next = (XW'(n) > XW'(RECENT_SPAN)) ? CW'(XW'(n) - XW'(RECENT_SPAN)) : '0;
        ix_next = (XW'(n) > XW'(RECENT_SPAN)) ? CW'(XW'(n) - XW'(RECENT_SPAN)) : '0;
        state_next = S_REC_AI;
      end
      S_REC_AI: begin
        h_log = ix;
        state_next = S_REC_AU;
      end
      S_REC_AU: begin
        rval_next = h_rdata;
        jx_next = rstart;
        fr_next = '0;
        state_next = S_REC_BI;
      end
      S_REC_BI: begin
        h_log = jx;
        state_next = S_REC_BU;
      end
      S_REC_BU: begin
        fr_new = fr + RFW'(h_rdata == rval);
        fr_next = fr_new;
        if (jx == n - CW'(1)) begin
          ix_next = ix + CW'(1);
          nxt = (ix == n - CW'(1)) ? S_PREV : S_REC_AI;
          if (fr_new >= RFW'(MIN_REPEATS)) begin
            of_go = 1'b1;
            of_addr = rval;
            of_score = SW'(SCORE_RECENT) + SW'(fr_new);
            of_ret = nxt;
          end else begin
            state_next = nxt;
          end
        end else begin
          jx_next = jx + CW'(1);
          state_next = S_REC_BI;
        end
      end
      S_PREV: begin
        of_go = 1'b1;
        of_addr = last;
        of_score = SW'(SCORE_PREV);
        of_ret = S_PREV2;
      end
      S_PREV2: begin
        if (n >= CW'(2)) begin
          of_go = 1'b1;
          of_addr = prev;
          of_score = SW'(SCORE_PREV2);
          of_ret = S_WIN_INIT;
        end else begin
          state_next = S_WIN_INIT;
        end
      end
      S_WIN_INIT: begin
        ck_next = '0;
        state_next = S_WIN_I;
      end
      S_WIN_I: begin
        c_raddr = ck;
        state_next = S_WIN_U;
      end
      // highest score wins, ties go to the lower address
      S_WIN_U: begin
        if (ck == '0 || eff > bs || (eff == bs && ca < ba)) begin
          bs_next = eff;
          ba_next = ca;
        end
        if (KCW'(ck) + KCW'(1) == cand_cnt) begin
          pred_next = ba_next;
          state_next = S_DONE;
        end else begin
          ck_next = ck + KW'(1);
          state_next = S_WIN_I;
        end
      end
      S_OF_CHK: begin
        if (cand_cnt == '0) begin
          c_we = 1'b1;
          c_waddr = '0;
          c_wdata = {oaddr, otrans ? SW'(0) : oscore, otrans ? CW'(1) : CW'(0)};
          cand_cnt_next = KCW'(1);
          state_next = ret;
        end else begin
          ck_next = '0;
          state_next = S_OF_I;
        end
      end
      S_OF_I: begin
        c_raddr = ck;
        state_next = S_OF_U;
      end
      S_OF_U: begin
        if (ca == oaddr) begin
          c_we = 1'b1;
          c_waddr = ck;
          if (otrans) begin
            c_wdata = {ca, cs, ct + CW'(1)};
          end else begin
            c_wdata = {ca, (oscore > cs) ? oscore : cs, ct};
          end
          state_next = ret;
        end else if (KCW'(ck) + KCW'(1) == cand_cnt) begin
          // drop new addresses once the table is full
          if (cand_cnt < KCW'(CANDIDATE_LIMIT)) begin
            c_we = 1'b1;
            c_waddr = cand_cnt[KW-1:0];
            c_wdata = {oaddr, otrans ? SW'(0) : oscore, otrans ? CW'(1) : CW'(0)};
            cand_cnt_next = cand_cnt + KCW'(1);
          end
          state_next = ret;
        end else begin
          ck_next = ck + KW'(1);
          state_next = S_OF_I;
        end
      end
      S_DONE: begin
        if (!outv || !prediction_stall) begin
          outd_next = pred;
          outv_next = 1'b1;
          h_we = 1'b1;
          if (XW'(n) < XW'(HISTORY_DEPTH)) begin
            h_waddr = phys(n, head);
            n_next = n + CW'(1);
          end else begin
            // overwrite the oldest word and advance the ring
            h_waddr = head;
            head_next = (head == HW'(HISTORY_DEPTH - 1)) ? '0 : head + HW'(1);
          end
          prev_next = last;
          last_next = cur;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (of_go) begin
      oaddr_next = of_addr;
      oscore_next = of_score;
      otrans_next = of_trans;
      ret_next = of_ret;
      state_next = S_OF_CHK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      head <= '0;
      cand_cnt <= '0;
      outv <= 1'b0;
    end else begin
      state <= state_next;
      n <= n_next;
      head <= head_next;
      cand_cnt <= cand_cnt_next;
      outv <= outv_next;
    end
  end

  always_ff @(posedge clk) begin
    ret <= ret_next;
    last <= last_next;
    prev <= prev_next;
    cur <= cur_next;
    pred <= pred_next;
    rval <= rval_next;
    p <= p_next;
    o <= o_next;
    dc <= dc_next;
    i <= i_next;
    fs <= fs_next;
    best_cnt <= best_cnt_next;
    pa <= pa_next;
    pb <= pb_next;
    cur_d <= cur_d_next;
    best <= best_next;
    predv <= predv_next;
    k <= k_next;
    ix <= ix_next;
    jx <= jx_next;
    rstart <= rstart_next;
    fr <= fr_next;
    ck <= ck_next;
    oaddr <= oaddr_next;
    oscore <= oscore_next;
    otrans <= otrans_next;
    ba <= ba_next;
    bs <= bs_next;
    outd <= outd_next;
    if (d_shift) begin
      for (int s = STRIDE_SPAN - 1; s > 0; s--) begin
        diffs[s] <= diffs[s-1];
      end
      diffs[0] <= d_new;
    end
  end

  a_cand_bound: assert property (@(posedge clk) disable iff (rst)
    cand_cnt <= KCW'(CANDIDATE_LIMIT))
    else $error("candidate count past limit");

  a_head_full: assert property (@(posedge clk) disable iff (rst)
    (head != '0) |-> (XW'(n) == XW'(HISTORY_DEPTH)))
    else $error("ring head moved before history filled");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(outv) |-> ($past(state) == S_DONE))
    else $error("result loaded outside done state");

  a_win_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_WIN_I) |-> (cand_cnt != '0))
    else $error("winner scan over empty table");

endmodule

@@ sim/multi_strategy_address_predictor_checker.sv @@
// Prediction checker: watches both channels, predicts each word and compares.
module multi_strategy_address_predictor_checker
  import msap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        address_valid,
  input  logic        address_stall,
  input  logic [63:0] address,
  input  logic        prediction_valid,
  input  logic        prediction_stall,
  input  logic [63:0] prediction,
  output int          failures,
  output int          pending
);

  localparam int HIST_DEPTH = 1024;
  localparam int CAND_LIMIT = 256;
  localparam int PERIOD_MAX = 16;
  localparam int STRIDE_WIN = 8;
  localparam int RECENT_WIN = 64;

  logic [63:0] hist [$];
  logic [63:0] cand_addr [$];
  int unsigned cand_score [$];
  logic [63:0] expected_preds [$];

  function automatic void offer(logic [63:0] a, int unsigned s);
    foreach (cand_addr[k]) begin
      if (cand_addr[k] == a) begin
        if (s > cand_score[k]) cand_score[k] = s;
        return;
      end
    end
    if (cand_addr.size() < CAND_LIMIT) begin
      cand_addr.push_back(a);
      cand_score.push_back(s & 13'h1fff);
    end
  endfunction

  function automatic logic [63:0] predict_next(logic [63:0] a);
    int n;
    int dc;
    int best_cnt;
    int f;
    int start;
    int win;
    bit same;
    logic [63:0] diffs [STRIDE_WIN];
    logic [63:0] best;
    logic [63:0] last;
    logic [63:0] p;
    logic [63:0] s;
    n = hist.size();
    cand_addr.delete();
    cand_score.delete();
    if (n == 0) return a + FIRST_STEP;
    last = hist[n-1];
    // shortest repeating block at the tail
    for (int pp = 1; pp <= PERIOD_MAX && n >= 2*pp; pp++) begin
      same = 1;
      for (int o = 0; o < pp; o++)
        if (hist[n-2*pp+o] != hist[n-pp+o]) same = 0;
      if (same) begin
        for (int o = 0; o < pp; o++) offer(hist[n-pp+o], SCORE_REPEAT - o);
        break;
      end
    end
    if (n >= 2) begin
      dc = (n - 1 > STRIDE_WIN) ? STRIDE_WIN : n - 1;
      for (int i = 0; i < dc; i++) diffs[i] = hist[n-dc+i] - hist[n-dc+i-1];
      best_cnt = 0;
      best = 0;
      for (int i = 0; i < dc; i++) begin
        f = 0;
        for (int j = 0; j < dc; j++) if (diffs[i] == diffs[j]) f++;
        if (f > best_cnt) begin
          best_cnt = f;
          best = diffs[i];
        end
      end
      if (best_cnt >= MIN_REPEATS && best != 0) begin
        for (int k = 1; k <= STRIDE_STEPS; k++) begin
          p = last + best * k;
          if (!p[63]) offer(p, SCORE_STRIDE + best_cnt - k);
        end
      end else begin
        s = last - hist[n-2];
        p = last + s;
        if (s != 0 && !p[63]) offer(p, SCORE_LATEST);
      end
      for (int j = 0; j + 1 < n; j++) begin
        if (hist[j] == last) begin
          f = 0;
          for (int m = 0; m + 1 < n; m++)
            if (hist[m] == last && hist[m+1] == hist[j+1]) f++;
          offer(hist[j+1], SCORE_TRANS + TRANS_STEP * f);
        end
      end
    end
    start = (n > RECENT_WIN) ? n - RECENT_WIN : 0;
    for (int i = start; i < n; i++) begin
      f = 0;
      for (int j = start; j < n; j++) if (hist[i] == hist[j]) f++;
      if (f >= MIN_REPEATS) offer(hist[i], SCORE_RECENT + f);
    end
    offer(last, SCORE_PREV);
    if (n >= 2) offer(hist[n-2], SCORE_PREV2);
    win = 0;
    for (int k = 1; k < cand_addr.size(); k++)
      if (cand_score[k] > cand_score[win] ||
          (cand_score[k] == cand_score[win] && cand_addr[k] < cand_addr[win]))
        win = k;
    return cand_addr[win];
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    failures++;
  endtask

  assign pending = expected_preds.size();

  initial failures = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (address_valid && !address_stall) begin
        expected_preds.push_back(predict_next(address));
        if (hist.size() >= HIST_DEPTH) void'(hist.pop_front());
        hist.push_back(address);
      end
      if (prediction_valid && !prediction_stall) begin
        if (expected_preds.size() == 0)
          report("unexpected word", prediction, '0);
        else if (prediction != expected_preds[0])
          report("prediction", prediction, expected_preds.pop_front());
        else
          void'(expected_preds.pop_front());
      end
    end
  end
endmodule

@@ sim/multi_strategy_address_predictor_core_test.sv @@
// Testbench top: drives address words, stalls the output, gives the verdict.
module multi_strategy_address_predictor_core_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        address_valid = 0;
  logic        address_stall;
  logic [63:0] address = '0;
  logic        prediction_valid;
  logic        prediction_stall = 0;
  logic [63:0] prediction;
  int          failures;
  int          pending;
  int          cycles = 0;
  logic [63:0] pattern [16];

  localparam int CYCLE_LIMIT = 40000000;

  always #1 clk = ~clk;

  multi_strategy_address_predictor_core u_top (.*);

  multi_strategy_address_predictor_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall: alternate quiet stretches with random stalling
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        prediction_stall <= (mode == 0) ? 1'b0 :
                            (mode == 1) ? ($urandom_range(0, 3) == 0) :
                                          ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send(logic [63:0] a);
    address_valid <= 1'b1;
    address <= a;
    @(posedge clk);
    while (address_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap();
    address_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int kind;
    int len;
    logic [63:0] base;
    logic [63:0] stride;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: wrap on first word, extremes, repeat, negative strides
    send(64'hffff_ffff_ffff_fffe);
    send(64'h0);
    send(64'hffff_ffff_ffff_ffff);
    send(64'h0);
    send(64'hffff_ffff_ffff_ffff);
    send(64'h7fff_ffff_ffff_fff0);
    send(64'h7fff_ffff_ffff_fff8);
    send(64'h7fff_ffff_ffff_fff0);
    send(64'h7fff_ffff_ffff_ffe8);
    for (int i = 0; i < 6; i++) send(64'h1000 + 64'h40 * i);
    for (int i = 0; i < 6; i++) send(64'h100 - 64'h10 * i);
    for (int i = 0; i < 4; i++) send(64'h5555_aaaa_0000_1234);
    // random: mostly structured sequences, some noise
    for (int i = 0; i < 115; ) begin
      kind = $urandom_range(0, 4);
      len = $urandom_range(3, 12);
      base = ($urandom_range(0, 3) == 0) ? rand64() : {48'h0, 16'($urandom())};
      stride = {{56{1'b0}}, 8'($urandom())} << $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) stride = -stride;
      for (int k = 0; k < 16; k++) pattern[k] = base + 64'h100 * $urandom_range(0, 7);
      for (int k = 0; k < len; k++) begin
        case (kind)
          0: send(base + stride * k);
          1: send(pattern[k % ($urandom_range(0, 1) ? 3 : 5)]);
          2: send(pattern[k % 2]);
          3: send(pattern[$urandom_range(0, 3)]);
          default: send(rand64());
        endcase
        i++;
        if ($urandom_range(0, 3) == 0) gap();
      end
      if ($urandom_range(0, 1)) gap();
    end
    address_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
